[rtl/trst_pkg.sv]
package trst_pkg;

    // slot table size
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = 3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    // highest key id that yields a key event
    localparam logic [3:0] KEY_ID_MAX = 4'd4;

    // report types from status bits 6:5
    localparam logic [1:0] TYPE_SCREEN = 2'd1;
    localparam logic [1:0] TYPE_KEY    = 2'd2;

    // record kinds on the result channel
    localparam logic [1:0] KIND_SLOT = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_SYNC = 2'd2;

    // one slot table entry
    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  strength;
        logic        active;
    } slot_entry_t;

    localparam slot_entry_t SLOT_RESET = '{pos_x: 12'd0, pos_y: 12'd0,
                                           strength: 8'd0, active: 1'b1};

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_KEY,
        ST_SYNC
    } seq_state_t;

endpackage

[rtl/touch_report_slot_tracker.sv]
// A screen report is written to the slot table; the slots are read in READ and EMIT and loaded
// into the output register, and the sync record follows the last slot record. A key report's
// event is loaded from KEY. Reports are accepted only in IDLE; a dropped one leaves it there.
// The slot table's single read port walks one slot per cycle unless an active slot waits on the
// result channel. Reset (aresetn low, synchronous) clears the sequencer, the output valid and
// the per-slot valid bits, so every slot reads as zeroed and active.
module touch_report_slot_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status_byte[7:0], coord_high_byte[15:8], x_low_byte[23:16],
    // y_low_byte[31:24], pressure_byte[39:32]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_index[2:0], pos_x[14:3], pos_y[26:15], touch_strength[34:27],
    // key_index[38:35], key_down[39]
    output logic [39:0] m_tdata,
    // record_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import trst_pkg::*;

    // slot table memory and per-entry valid bits
    slot_entry_t slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;

    seq_state_t state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    slot_entry_t rd_data_reg;
    logic rd_valid_reg;
    logic [3:0] key_id_reg;
    logic key_down_reg;

    logic m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic m_tlast_reg;

    // decoded input fields
    logic [7:0] status;
    logic [1:0] rpt_type;
    logic pressed;
    logic [3:0] rpt_id;
    logic [11:0] in_x, in_y;
    logic [7:0] in_pressure;
    logic s_accept, id_ok;

    // table access and output load controls
    logic rd_en, wr_en;
    logic [SLOT_W-1:0] rd_addr, wr_addr;
    slot_entry_t wr_data;
    slot_entry_t cur;
    logic out_free, emit_go;
    logic out_load;
    logic [39:0] out_data;
    logic [1:0] out_kind;
    logic out_last;

    assign status      = s_tdata[7:0];
    assign rpt_type    = status[6:5];
    assign pressed     = status[4];
    assign rpt_id      = status[3:0];
    assign in_x        = {s_tdata[11:8], s_tdata[23:16]};
    assign in_y        = {s_tdata[15:12], s_tdata[31:24]};
    assign in_pressure = s_tdata[39:32];
    assign id_ok       = rpt_id <= 4'(NUM_SLOTS);
    assign s_accept    = s_tvalid && s_tready;

    // entry under inspection: never-written slots read as reset value
    assign cur      = rd_valid_reg ? rd_data_reg : SLOT_RESET;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = !cur.active || out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_accept && id_ok) begin
                    if (rpt_type == TYPE_SCREEN) begin
                        if (rpt_id != 4'd0) state_next = ST_READ;
                    end else if (rpt_type == TYPE_KEY) begin
                        if (rpt_id != 4'd0 && rpt_id <= KEY_ID_MAX) state_next = ST_KEY;
                        else state_next = ST_SYNC;
                    end else begin
                        state_next = ST_SYNC;
                    end
                end
            end
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_go) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == SLOT_LAST) state_next = ST_SYNC;
                end
            end
            ST_KEY: begin
                if (out_free) state_next = ST_SYNC;
            end
            ST_SYNC: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: table accesses and record loads
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = cur;
        out_load = 1'b0;
        out_data = '0;
        out_kind = KIND_SYNC;
        out_last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept && id_ok && rpt_type == TYPE_SCREEN && rpt_id != 4'd0) begin
                    wr_en   = 1'b1;
                    wr_addr = SLOT_W'(rpt_id - 4'd1);
                    wr_data = '{pos_x: in_x, pos_y: in_y,
                                strength: pressed ? in_pressure : 8'd0, active: 1'b1};
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_EMIT: begin
                if (cur.active && out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_SLOT;
                    out_data = {5'd0, cur.strength, cur.pos_y, cur.pos_x, idx_reg};
                    // a lifted slot is reported once, then retired
                    if (cur.strength == 8'd0) begin
                        wr_en          = 1'b1;
                        wr_data.active = 1'b0;
                    end
                end
                if (emit_go && idx_reg != SLOT_LAST) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + 1'b1;
                end
            end
            ST_KEY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_KEY;
                    out_data = {key_down_reg, key_id_reg, 35'd0};
                end
            end
            ST_SYNC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_SYNC;
                    out_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // slot table memory
    always_ff @(posedge aclk) begin
        if (wr_en) slot_mem[wr_addr] <= wr_data;
        if (rd_en) begin
            rd_data_reg  <= slot_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (wr_en) valid_reg[wr_addr] <= 1'b1;
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_id_reg   <= rpt_id;
            key_down_reg <= pressed;
        end
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/trst_checker.sv]
module trst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import trst_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // last marks exactly the sync record
    a_last_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_SYNC)
        else $error("last on a non-sync record");

    a_sync_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SYNC |-> m_tlast && m_tdata == 40'd0)
        else $error("sync record malformed");

    // key events only for known keys
    a_key_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_KEY |->
            m_tdata[38:35] != 4'd0 && m_tdata[38:35] <= KEY_ID_MAX)
        else $error("key event with bad key id");

    // slot records name a real slot
    a_slot_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SLOT |-> m_tdata[2:0] <= SLOT_LAST && m_tdata[39:35] == 5'd0)
        else $error("slot record with bad slot index");

endmodule

bind touch_report_slot_tracker trst_checker u_trst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
